### src/mie_pkg.sv
package mie_pkg;

   localparam int unsigned OPER_WIDTH_DEFAULT = 32;
   localparam int unsigned DATA_WIDTH         = 32;
   localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = 32'd2;

endpackage

### src/modular_inverse_ext_euclid_core.sv
// Extended Euclid: one shift-subtract divider is run once per Euclid quotient step; a zero
//   value or modulus skips the divider and is answered with no_inverse set.
// One request at a time; req_tready is high only while idle. A finished result waits in
//   the output register while the next request runs.
// Reset (synchronous, active high) clears control state and sets the modulus to 2.
module modular_inverse_ext_euclid_core #(
   parameter int unsigned WIDTH = mie_pkg::OPER_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mie_pkg::DATA_WIDTH-1:0]  csr_data,    // modulus
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mie_pkg::DATA_WIDTH-1:0]  req_tdata,   // [31:0] value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mie_pkg::DATA_WIDTH-1:0]  rsp_tdata,   // [31:0] inverse
   output logic                            rsp_tuser    // [0] no_inverse
);

   localparam int unsigned DW = mie_pkg::DATA_WIDTH;
   localparam int unsigned KW = $clog2(WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_SUB,
      ST_UPDATE,
      ST_FINAL,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [DW-1:0]        modulus_ff, modulus_in;
   logic [WIDTH-1:0]     rem_ff, rem_in;       // running dividend / remainder
   logic [WIDTH-1:0]     div_ff, div_in;       // aligned divisor
   logic [KW-1:0]        k_ff, k_in;           // divisor shift count
   logic [WIDTH-1:0]     acc_ff, acc_in;       // q * c_cur, built msb first
   logic [WIDTH-1:0]     r_cur_ff, r_cur_in;
   logic [WIDTH-1:0]     c_prev_ff, c_prev_in;
   logic [WIDTH-1:0]     c_cur_ff, c_cur_in;
   logic                 neg_ff, neg_in;
   logic                 fail_ff, fail_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [DW-1:0]        rsp_tdata_ff, rsp_tdata_in;
   logic                 rsp_tuser_ff, rsp_tuser_in;

   logic [WIDTH+DW-1:0]  value_ext;
   logic [WIDTH+DW-1:0]  modulus_ext;
   logic [WIDTH+DW-1:0]  inv_ext;
   logic [WIDTH-1:0]     value_w;
   logic [WIDTH-1:0]     mod_w;
   logic [WIDTH-1:0]     inv_w;
   logic [WIDTH:0]       div_dbl;
   logic                 sub_bit;
   logic                 out_free;

   assign value_ext   = {{WIDTH{1'b0}}, req_tdata};
   assign modulus_ext = {{WIDTH{1'b0}}, modulus_ff};
   assign value_w     = value_ext[WIDTH-1:0];
   assign mod_w       = modulus_ext[WIDTH-1:0];
   assign div_dbl     = {div_ff, 1'b0};
   assign sub_bit     = (rem_ff >= div_ff);
   assign out_free    = !rsp_tvalid_ff || rsp_tready;

   // final mapping: c_cur_ff holds c mod m here
   always_comb begin
      if (fail_ff) begin
         inv_w = '0;
      end else if (neg_ff && (c_cur_ff != '0)) begin
         inv_w = mod_w - c_cur_ff;
      end else if (neg_ff) begin
         inv_w = '0;
      end else begin
         inv_w = c_cur_ff;
      end
   end
   assign inv_ext = {{DW{1'b0}}, inv_w};

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_comb begin
      state_in      = state_ff;
      modulus_in    = modulus_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      r_cur_in      = r_cur_ff;
      c_prev_in     = c_prev_ff;
      c_cur_in      = c_cur_ff;
      neg_in        = neg_ff;
      fail_in       = fail_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      if (csr_valid) begin
         modulus_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rem_in    = mod_w;
               div_in    = value_w;
               r_cur_in  = value_w;
               k_in      = '0;
               acc_in    = '0;
               c_prev_in = '0;
               c_cur_in  = {{(WIDTH-1){1'b0}}, 1'b1};
               neg_in    = 1'b0;
               if ((mod_w == '0) || (value_w == '0)) begin
                  fail_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  fail_in  = 1'b0;
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_ALIGN: begin
            if (!div_ff[WIDTH-1] && (div_dbl <= {1'b0, rem_ff})) begin
               div_in = div_dbl[WIDTH-1:0];
               k_in   = k_ff + 1'b1;
            end else begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            if (sub_bit) begin
               rem_in = rem_ff - div_ff;
               acc_in = {acc_ff[WIDTH-2:0], 1'b0} + c_cur_ff;
            end else begin
               acc_in = {acc_ff[WIDTH-2:0], 1'b0};
            end
            if (k_ff == '0) begin
               state_in = ST_UPDATE;
            end else begin
               div_in = {1'b0, div_ff[WIDTH-1:1]};
               k_in   = k_ff - 1'b1;
            end
         end
         ST_UPDATE: begin
            if (rem_ff == '0) begin
               state_in = ST_FINAL;
            end else begin
               r_cur_in  = rem_ff;
               c_prev_in = c_cur_ff;
               c_cur_in  = c_prev_ff + acc_ff;
               neg_in    = !neg_ff;
               rem_in    = r_cur_ff;
               div_in    = rem_ff;
               k_in      = '0;
               acc_in    = '0;
               state_in  = ST_ALIGN;
            end
         end
         ST_FINAL: begin
            fail_in = (r_cur_ff != {{(WIDTH-1){1'b0}}, 1'b1});
            if (c_cur_ff >= mod_w) begin
               c_cur_in = c_cur_ff - mod_w;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = inv_ext[DW-1:0];
               rsp_tuser_in  = fail_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         modulus_ff    <= mie_pkg::MODULUS_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         modulus_ff    <= modulus_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      k_ff         <= k_in;
      acc_ff       <= acc_in;
      r_cur_ff     <= r_cur_in;
      c_prev_ff    <= c_prev_in;
      c_cur_ff     <= c_cur_in;
      neg_ff       <= neg_in;
      fail_ff      <= fail_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

endmodule

### test/modular_inverse_ext_euclid_core_test.sv
module modular_inverse_ext_euclid_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DATA_WIDTH = mie_pkg::DATA_WIDTH;
   localparam int unsigned STALL_LIMIT = 20000;
   localparam int unsigned SQUEEZE_CYCLES = 2000;
   localparam int unsigned DRAIN_CYCLES = 600;
   localparam int PHASES = 12;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] inverse;
      logic                  no_inverse;
   } inv_type;

   typedef enum bit [1:0] {ROW_CSR, ROW_PRED, ROW_KNOWN} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [DATA_WIDTH-1:0] data;
      logic [DATA_WIDTH-1:0] inverse;
      logic                  no_inverse;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [DATA_WIDTH-1:0] csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_WIDTH-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DATA_WIDTH-1:0] rsp_tdata;
   logic                  rsp_tuser;

   inv_type               pending_inverses[$];
   inv_type               want;
   logic [DATA_WIDTH-1:0] modulus_now = mie_pkg::MODULUS_RESET;
   logic [DATA_WIDTH-1:0] next_modulus;
   int unsigned           phase_len;
   int unsigned           quiet;
   int unsigned           errors;
   int unsigned           sent;
   int unsigned           received;
   int unsigned           refused;
   int unsigned           settings;
   bit                    calm;
   bit                    squeeze_req;

   // reset modulus is 2, so the first rows run without a write
   row_type plan [0:27] = '{
      '{ROW_KNOWN, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{ROW_KNOWN, 32'h0000_0001, 32'h0000_0001, 1'b0},
      '{ROW_KNOWN, 32'h0000_0002, 32'h0000_0000, 1'b1},
      '{ROW_KNOWN, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0},
      '{ROW_CSR,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
      '{ROW_KNOWN, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{ROW_KNOWN, 32'h0000_0001, 32'h0000_0001, 1'b0},
      '{ROW_KNOWN, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1},
      '{ROW_KNOWN, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0},
      '{ROW_KNOWN, 32'h0000_0003, 32'h0000_0000, 1'b1},
      '{ROW_KNOWN, 32'h0000_0002, 32'h8000_0000, 1'b0},
      '{ROW_PRED,  32'hAAAA_AAAA, 32'h0000_0000, 1'b0},
      '{ROW_PRED,  32'h5555_5555, 32'h0000_0000, 1'b0},
      '{ROW_CSR,   32'h0000_0000, 32'h0000_0000, 1'b0},
      '{ROW_KNOWN, 32'h0000_0001, 32'h0000_0000, 1'b1},
      '{ROW_KNOWN, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1},
      '{ROW_CSR,   32'h0000_0001, 32'h0000_0000, 1'b0},
      '{ROW_KNOWN, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{ROW_KNOWN, 32'h0000_0001, 32'h0000_0000, 1'b0},
      '{ROW_KNOWN, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
      '{ROW_CSR,   32'h8000_0000, 32'h0000_0000, 1'b0},
      '{ROW_KNOWN, 32'h8000_0000, 32'h0000_0000, 1'b1},
      '{ROW_KNOWN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0},
      '{ROW_PRED,  32'h0000_0003, 32'h0000_0000, 1'b0},
      '{ROW_CSR,   32'hFFFF_FFFB, 32'h0000_0000, 1'b0},
      '{ROW_PRED,  32'hFFFF_FFFC, 32'h0000_0000, 1'b0},
      '{ROW_PRED,  32'h1234_5678, 32'h0000_0000, 1'b0},
      '{ROW_PRED,  32'hDEAD_BEEF, 32'h0000_0000, 1'b0}
   };

   modular_inverse_ext_euclid_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // coefficients kept as magnitude plus sign, as they alternate
   function automatic inv_type invert_mod(input logic [DATA_WIDTH-1:0] m,
                                          input logic [DATA_WIDTH-1:0] a);
      bit [63:0] r_old, r_new, c_old, c_new, q, r_next, c_next, red;
      bit        neg;
      inv_type   res;
      res = inv_type'{'0, 1'b1};
      if (m == 0 || a == 0) return res;
      r_old = m;
      r_new = a;
      c_old = 0;
      c_new = 1;
      neg = 1'b0;
      while (r_old % r_new != 0) begin
         q = r_old / r_new;
         r_next = r_old % r_new;
         c_next = c_old + q * c_new;
         r_old = r_new;
         r_new = r_next;
         c_old = c_new;
         c_new = c_next;
         neg = !neg;
      end
      if (r_new != 1) return res;
      red = c_new % m;
      res.no_inverse = 1'b0;
      if (neg && red != 0) res.inverse = m - red[DATA_WIDTH-1:0];
      else if (neg) res.inverse = '0;
      else res.inverse = red[DATA_WIDTH-1:0];
      return res;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_value(input logic [DATA_WIDTH-1:0] m);
      logic [DATA_WIDTH-1:0] v;
      case ($urandom_range(0, 15))
         0: v = '0;
         1, 2: v = $urandom_range(1, 300);
         3, 4: v = m - $urandom_range(0, 4);
         5: v = m + $urandom_range(0, 4);
         6, 7: v = $urandom() << $urandom_range(1, 6);
         8, 9: v = $urandom_range(1, 32'h0FFF_FFFF) * 3;
         10, 11: v = (m > 1) ? $urandom_range(0, m - 1) : $urandom();
         default: v = $urandom();
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
                                  input logic [DATA_WIDTH-1:0] exp_val);
      errors++;
      if (errors <= 30)
         $display("mismatch %s at %0t: got %h, expected %h", what, $time, got, exp_val);
   endtask

   task automatic send_value(input logic [DATA_WIDTH-1:0] v, input bit known,
                             input inv_type typed);
      int unsigned gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      pending_inverses.push_back(known ? typed : invert_mod(modulus_now, v));
      sent++;
   endtask

   // only while idle: every request answered
   task automatic write_modulus(input logic [DATA_WIDTH-1:0] m);
      req_tvalid <= 1'b0;
      while (pending_inverses.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      modulus_now = m;
      settings++;
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (rsp_tuser === 1'b1) refused++;
         if (pending_inverses.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, '0);
         end else begin
            want = pending_inverses.pop_front();
            if (rsp_tdata !== want.inverse)
               report_mismatch("inverse", rsp_tdata, want.inverse);
            if (rsp_tuser !== want.no_inverse)
               report_mismatch("no_inverse", {31'b0, rsp_tuser}, {31'b0, want.no_inverse});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("timeout: nothing accepted for %0d cycles", quiet);
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // result side: random back-pressure, one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         if (squeeze_req) begin
            squeeze_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR)
            write_modulus(plan[i].data);
         else
            send_value(plan[i].data, plan[i].kind == ROW_KNOWN,
                       inv_type'{plan[i].inverse, plan[i].no_inverse});
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         calm = (ph == PHASES - 1);
         case (ph % 6)
            0: next_modulus = $urandom();
            1: next_modulus = $urandom_range(3, 1000);
            2: next_modulus = $urandom() | 32'h1;
            3: next_modulus = 32'h1 << $urandom_range(1, 31);
            4: next_modulus = 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: next_modulus = (ph == 5) ? mie_pkg::MODULUS_RESET
                                              : ($urandom() | 32'h8000_0000);
         endcase
         phase_len = (next_modulus == mie_pkg::MODULUS_RESET) ? 40 : 168;
         write_modulus(next_modulus);
         if (ph == 2) squeeze_req = 1'b1;
         repeat (phase_len) send_value(pick_value(next_modulus), 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests across %0d modulus writes, incl. zero, one and extremes",
               sent, settings);
      $display("%0d results checked, %0d with no inverse", received, refused);
      if (errors == 0 && pending_inverses.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
src/mie_pkg.sv
src/modular_inverse_ext_euclid_core.sv
test/modular_inverse_ext_euclid_core_test.sv
